### src/tpef_pkg.sv
// ----------------------------------------------------------------------------
// tpef_pkg
// Shared types, constants and helpers of the touch panel event filter.
// ----------------------------------------------------------------------------
package tpef_pkg;

    localparam int COORD_W      = 12;
    localparam int GAIN_W       = 18;
    localparam int OFFSET_W     = 17;
    localparam int COUNT_W      = 4;
    localparam int CFG_DATA_W   = 18;
    localparam int CFG_INDEX_W  = 3;
    localparam int SAMPLES_DEF  = 7;
    localparam int PROD_W       = GAIN_W + COORD_W + 1;
    localparam int SUM_W        = PROD_W + 1;
    localparam int FRAC_W       = 16;
    localparam int OFFSET_SHIFT = 12;

    localparam logic [GAIN_W-1:0]   GAIN_RST     = GAIN_W'(65536);
    localparam logic [OFFSET_W-1:0] OFFSET_RST   = '0;
    localparam logic [COORD_W-1:0]  MAX_X_RST    = COORD_W'(127);
    localparam logic [COORD_W-1:0]  MAX_Y_RST    = COORD_W'(95);
    localparam logic [COORD_W-1:0]  JITTER_RST   = COORD_W'(5);
    localparam logic [COUNT_W-1:0]  SETTLE_RST   = COUNT_W'(3);
    localparam logic [COUNT_W-1:0]  STABLE_MAX   = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_X       = 3'd0,
        REG_OFFSET_X     = 3'd1,
        REG_GAIN_Y       = 3'd2,
        REG_OFFSET_Y     = 3'd3,
        REG_MAX_X        = 3'd4,
        REG_MAX_Y        = 3'd5,
        REG_JITTER_LIMIT = 3'd6,
        REG_SETTLE_COUNT = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_MOVE = 2'd2,
        EV_UP   = 2'd3
    } event_kind_t;

    typedef enum logic {
        CMD_UP   = 1'b0,
        CMD_SCAN = 1'b1
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic scan_held;
    } q_status_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain_x;
        logic signed [OFFSET_W-1:0] offset_x;
        logic signed [GAIN_W-1:0]   gain_y;
        logic signed [OFFSET_W-1:0] offset_y;
        logic [COORD_W-1:0]         max_x;
        logic [COORD_W-1:0]         max_y;
        logic [COORD_W-1:0]         jitter_limit;
        logic [COUNT_W-1:0]         settle_count;
    } cfg_t;

    // (prod + offset * 4096) >> 16, negative gives zero, then clamp to maxv
    function automatic logic [COORD_W-1:0] map_axis(
        input logic signed [PROD_W-1:0]   prod,
        input logic signed [OFFSET_W-1:0] offset,
        input logic [COORD_W-1:0]         maxv
    );
        logic signed [SUM_W-1:0] off_ext;
        logic signed [SUM_W-1:0] sum;
        logic [SUM_W-FRAC_W-1:0] r;
        off_ext = {{(SUM_W-OFFSET_W-OFFSET_SHIFT){offset[OFFSET_W-1]}}, offset,
                   {OFFSET_SHIFT{1'b0}}};
        sum = {prod[PROD_W-1], prod} + off_ext;
        r = sum[SUM_W-1:FRAC_W];
        if (sum[SUM_W-1])
            map_axis = '0;
        else if (r > (SUM_W-FRAC_W)'(maxv))
            map_axis = maxv;
        else
            map_axis = r[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### src/touch_panel_event_filter.sv
// ----------------------------------------------------------------------------
// touch_panel_event_filter
// Median filter, linear calibration and debounce for a resistive touch panel.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    pen_down, raw_x, raw_y
//   out       out_valid / out_ready  event_kind, pos_x, pos_y
//   cfg       cfg_write              cfg_index, cfg_data
//
// Pen-down items that do not finish a scan are taken one per cycle unless
// the command queue is full or holds a scan. An item that finishes a scan
// is worked in the back part by the rank search, which visits one sample
// per cycle; the next scan item is held off until that scan leaves the
// command queue. A pen-up item is done once the result register is free.
// The result register lets the front keep taking items while a result
// waits. Reset is asynchronous and active low; no clearing pass.
// ----------------------------------------------------------------------------
module touch_panel_event_filter #(
    parameter int SAMPLES = tpef_pkg::SAMPLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             pen_down,
    input  logic [tpef_pkg::COORD_W-1:0]     raw_x,
    input  logic [tpef_pkg::COORD_W-1:0]     raw_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       event_kind,
    output logic [tpef_pkg::COORD_W-1:0]     pos_x,
    output logic [tpef_pkg::COORD_W-1:0]     pos_y,
    input  logic                             cfg_write,
    input  logic [tpef_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpef_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tpef_pkg::*;

    cfg_t               cfg_reg;
    q_status_t          q_status;
    cmd_t               push_cmd;
    cmd_t               head_cmd;
    logic               push;
    logic               pop;
    logic [COORD_W-1:0] x_samples [SAMPLES];
    logic [COORD_W-1:0] y_samples [SAMPLES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_x       <= GAIN_RST;
            cfg_reg.offset_x     <= OFFSET_RST;
            cfg_reg.gain_y       <= GAIN_RST;
            cfg_reg.offset_y     <= OFFSET_RST;
            cfg_reg.max_x        <= MAX_X_RST;
            cfg_reg.max_y        <= MAX_Y_RST;
            cfg_reg.jitter_limit <= JITTER_RST;
            cfg_reg.settle_count <= SETTLE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_GAIN_X:       cfg_reg.gain_x       <= cfg_data[GAIN_W-1:0];
                REG_OFFSET_X:     cfg_reg.offset_x     <= cfg_data[OFFSET_W-1:0];
                REG_GAIN_Y:       cfg_reg.gain_y       <= cfg_data[GAIN_W-1:0];
                REG_OFFSET_Y:     cfg_reg.offset_y     <= cfg_data[OFFSET_W-1:0];
                REG_MAX_X:        cfg_reg.max_x        <= cfg_data[COORD_W-1:0];
                REG_MAX_Y:        cfg_reg.max_y        <= cfg_data[COORD_W-1:0];
                REG_JITTER_LIMIT: cfg_reg.jitter_limit <= cfg_data[COORD_W-1:0];
                REG_SETTLE_COUNT: cfg_reg.settle_count <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tpef_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pen_down  (pen_down),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd),
        .x_samples (x_samples),
        .y_samples (y_samples)
    );

    tpef_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    tpef_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .x_samples  (x_samples),
        .y_samples  (y_samples),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .pos_x      (pos_x),
        .pos_y      (pos_y)
    );

endmodule

### src/tpef_queue.sv
// ----------------------------------------------------------------------------
// tpef_queue
// Two-entry command queue between the sample front and the filter back.
// ----------------------------------------------------------------------------
module tpef_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tpef_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output tpef_pkg::cmd_t     head_cmd,
    output tpef_pkg::q_status_t status
);
    import tpef_pkg::*;

    cmd_t       entry_reg [2];
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head_cmd         = entry_reg[rd_ptr_reg];
    assign status.empty     = (count_reg == 2'd0);
    assign status.full      = (count_reg == 2'd2);
    assign status.scan_held = ((count_reg != 2'd0) && (entry_reg[rd_ptr_reg] == CMD_SCAN))
                           || ((count_reg == 2'd2) && (entry_reg[~rd_ptr_reg] == CMD_SCAN));

    always_comb
    begin
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue push while full");

    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue pop while empty");

endmodule

### src/tpef_front.sv
// ----------------------------------------------------------------------------
// tpef_front
// Accepts sample items, stores pen-down pairs and queues scan and pen-up work.
// ----------------------------------------------------------------------------
module tpef_front #(
    parameter int SAMPLES = tpef_pkg::SAMPLES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         pen_down,
    input  logic [tpef_pkg::COORD_W-1:0] raw_x,
    input  logic [tpef_pkg::COORD_W-1:0] raw_y,
    input  tpef_pkg::q_status_t          q_status,
    output logic                         push,
    output tpef_pkg::cmd_t               push_cmd,
    output logic [tpef_pkg::COORD_W-1:0] x_samples [SAMPLES],
    output logic [tpef_pkg::COORD_W-1:0] y_samples [SAMPLES]
);
    import tpef_pkg::*;

    localparam int IW = $clog2(SAMPLES);

    logic [COORD_W-1:0] x_samples_reg [SAMPLES];
    logic [COORD_W-1:0] y_samples_reg [SAMPLES];
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      idx_next;
    logic               accept;
    logic               last_sample;

    // samples stay frozen while a finished scan waits in the queue
    assign in_ready    = !q_status.full && !q_status.scan_held;
    assign accept      = in_valid && in_ready;
    assign last_sample = (idx_reg == IW'(SAMPLES - 1));
    assign push        = accept && (!pen_down || last_sample);
    assign push_cmd    = pen_down ? CMD_SCAN : CMD_UP;
    assign x_samples   = x_samples_reg;
    assign y_samples   = y_samples_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (!pen_down || last_sample)
                idx_next = '0;
            else
                idx_next = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && pen_down)
        begin
            x_samples_reg[idx_reg] <= raw_x;
            y_samples_reg[idx_reg] <= raw_y;
        end
    end

    a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IW'(SAMPLES - 1))
        else $error("sample index out of range");

endmodule

### src/tpef_back.sv
// ----------------------------------------------------------------------------
// tpef_back
// Median search, calibration mapping, jitter debounce and result register.
// ----------------------------------------------------------------------------
module tpef_back #(
    parameter int SAMPLES = tpef_pkg::SAMPLES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tpef_pkg::cfg_t               cfg,
    input  tpef_pkg::q_status_t          q_status,
    input  tpef_pkg::cmd_t               head_cmd,
    output logic                         pop,
    input  logic [tpef_pkg::COORD_W-1:0] x_samples [SAMPLES],
    input  logic [tpef_pkg::COORD_W-1:0] y_samples [SAMPLES],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   event_kind,
    output logic [tpef_pkg::COORD_W-1:0] pos_x,
    output logic [tpef_pkg::COORD_W-1:0] pos_y
);
    import tpef_pkg::*;

    localparam int IW  = $clog2(SAMPLES);
    localparam int CW  = $clog2(SAMPLES + 1);
    localparam int MID = SAMPLES / 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_MULT,
        ST_MAP,
        ST_DECIDE
    } state_t;

    state_t                    state_reg;
    logic [IW-1:0]             step_reg;
    logic [COUNT_W-1:0]        stable_reg;
    logic [COORD_W-1:0]        held_x_reg;
    logic [COORD_W-1:0]        held_y_reg;
    logic                      pressed_reg;
    logic                      out_valid_reg;
    event_kind_t               kind_reg;
    logic [COORD_W-1:0]        pos_x_reg;
    logic [COORD_W-1:0]        pos_y_reg;

    logic [COORD_W-1:0]        wx_reg [SAMPLES];
    logic [COORD_W-1:0]        wy_reg [SAMPLES];
    logic [COORD_W-1:0]        med_x_reg;
    logic [COORD_W-1:0]        med_y_reg;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic [COORD_W-1:0]        px_reg;
    logic [COORD_W-1:0]        py_reg;

    logic [CW-1:0]             lt_x;
    logic [CW-1:0]             le_x;
    logic [CW-1:0]             lt_y;
    logic [CW-1:0]             le_y;
    logic                      hit_x;
    logic                      hit_y;
    logic                      stable_hit;
    logic [COUNT_W-1:0]        stable_new;
    logic                      report;

    assign pop = (state_reg == ST_IDLE) && !q_status.empty
              && ((head_cmd == CMD_SCAN) || !out_valid_reg);

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;

    // rank of the candidate in slot zero against the whole set
    always_comb
    begin
        lt_x = '0;
        le_x = '0;
        lt_y = '0;
        le_y = '0;
        for (int i = 0; i < SAMPLES; i++)
        begin
            lt_x = lt_x + CW'(wx_reg[i] <  wx_reg[0]);
            le_x = le_x + CW'(wx_reg[i] <= wx_reg[0]);
            lt_y = lt_y + CW'(wy_reg[i] <  wy_reg[0]);
            le_y = le_y + CW'(wy_reg[i] <= wy_reg[0]);
        end
        hit_x = (lt_x <= CW'(MID)) && (le_x > CW'(MID));
        hit_y = (lt_y <= CW'(MID)) && (le_y > CW'(MID));
    end

    always_comb
    begin
        stable_hit = (stable_reg == '0)
                  || ((abs_diff(px_reg, held_x_reg) < cfg.jitter_limit)
                   && (abs_diff(py_reg, held_y_reg) < cfg.jitter_limit));
        if (!stable_hit)
            stable_new = '0;
        else if (stable_reg == STABLE_MAX)
            stable_new = STABLE_MAX;
        else
            stable_new = stable_reg + COUNT_W'(1);
        report = (stable_new >= cfg.settle_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            stable_reg    <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            pressed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= EV_NONE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (head_cmd == CMD_SCAN)
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_MEDIAN;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= pressed_reg ? EV_UP : EV_NONE;
                            pos_x_reg     <= pressed_reg ? held_x_reg : '0;
                            pos_y_reg     <= pressed_reg ? held_y_reg : '0;
                            stable_reg    <= '0;
                            pressed_reg   <= 1'b0;
                        end
                    end
                end
                ST_MEDIAN:
                begin
                    step_reg <= step_reg + IW'(1);
                    if (step_reg == IW'(SAMPLES - 1))
                        state_reg <= ST_MULT;
                end
                ST_MULT:
                    state_reg <= ST_MAP;
                ST_MAP:
                    state_reg <= ST_DECIDE;
                ST_DECIDE:
                begin
                    if (!(report && out_valid_reg))
                    begin
                        stable_reg <= stable_new;
                        if (stable_hit)
                        begin
                            held_x_reg <= px_reg;
                            held_y_reg <= py_reg;
                        end
                        if (report)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= pressed_reg ? EV_MOVE : EV_DOWN;
                            pos_x_reg     <= stable_hit ? px_reg : held_x_reg;
                            pos_y_reg     <= stable_hit ? py_reg : held_y_reg;
                            pressed_reg   <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // working copy of the scan, rotated one slot per cycle during the search
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (head_cmd == CMD_SCAN))
                begin
                    wx_reg <= x_samples;
                    wy_reg <= y_samples;
                end
            end
            ST_MEDIAN:
            begin
                if (hit_x)
                    med_x_reg <= wx_reg[0];
                if (hit_y)
                    med_y_reg <= wy_reg[0];
                for (int i = 0; i < SAMPLES - 1; i++)
                begin
                    wx_reg[i] <= wx_reg[i+1];
                    wy_reg[i] <= wy_reg[i+1];
                end
                wx_reg[SAMPLES-1] <= wx_reg[0];
                wy_reg[SAMPLES-1] <= wy_reg[0];
            end
            ST_MULT:
            begin
                prod_x_reg <= PROD_W'(cfg.gain_x * $signed({1'b0, med_x_reg}));
                prod_y_reg <= PROD_W'(cfg.gain_y * $signed({1'b0, med_y_reg}));
            end
            ST_MAP:
            begin
                px_reg <= map_axis(prod_x_reg, cfg.offset_x, cfg.max_x);
                py_reg <= map_axis(prod_y_reg, cfg.offset_y, cfg.max_y);
            end
            default:
            begin
            end
        endcase
    end

    a_step_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEDIAN) |-> (step_reg <= IW'(SAMPLES - 1)))
        else $error("median step out of range");

    a_release_reports_up : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pressed_reg) |-> (out_valid_reg && (kind_reg == EV_UP)))
        else $error("press cleared without up item");

    a_press_reports_down : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pressed_reg) |-> (out_valid_reg && (kind_reg == EV_DOWN)))
        else $error("press set without down item");

endmodule
